@@ rtl/slmt_pkg.sv @@
// shared types, field widths and codes of the set lcs match traceback unit
// used by slmt_ctrl, slmt_dp and set_lcs_match_traceback_unit
package slmt_pkg;

	localparam int DEF_MAX_CAND_LEN  = 32;
	localparam int DEF_MAX_QUERY_LEN = 32;
	localparam int DEF_SET_SIZE      = 8;

	localparam int OPC_W   = 3;
	localparam int ID_W    = 22;
	localparam int POS_W   = 5;
	localparam int CNT_W   = 6;
	localparam int PEN_W   = 12;
	localparam int PEN_MAX = 4095;
	localparam int CNT_MAX = 63;
	localparam int MAX_OUT = 32;

	typedef enum logic [OPC_W-1:0] {
		IN_APPEND_Q = 3'd0,
		IN_ADD_ID   = 3'd1,
		IN_CLOSE    = 3'd2,
		IN_COMPUTE  = 3'd3,
		IN_CLEAR_Q  = 3'd4
	} in_op_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_START,
		OP_ROW,
		OP_FILL_RD,
		OP_FILL_WR,
		OP_TB_INIT,
		OP_TB_HERE,
		OP_TB_UP,
		OP_STEP_UP,
		OP_TB_LEFT,
		OP_STEP_LEFT,
		OP_RECORD,
		OP_ACC,
		OP_PEN1,
		OP_PEN2,
		OP_EM_RD,
		OP_EM_LD,
		OP_NONE_LD,
		OP_FINISH
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ROW,
		ST_FILL_RD,
		ST_FILL_WR,
		ST_TB_INIT,
		ST_TB_CHECK,
		ST_TB_HERE,
		ST_TB_UP,
		ST_TB_UPCMP,
		ST_TB_LEFT,
		ST_ACC,
		ST_PEN1,
		ST_PEN2,
		ST_EM_RD,
		ST_EM_LD,
		ST_NONE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		dp_op_t op;
		logic   load_item;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic col_last;
		logic row_last;
		logic tb_live;
		logic up_eq;
		logic left_eq;
		logic has_hits;
		logic emit_last;
		logic out_free;
	} dp_status_t;

endpackage

@@ rtl/slmt_ctrl.sv @@
// controller state machine: sequences loads, table fill, traceback,
// penalty and result emission; depends on slmt_pkg
module slmt_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  logic [slmt_pkg::OPC_W-1:0] opcode,
	input  slmt_pkg::dp_status_t      status,
	output slmt_pkg::dp_cmd_t         cmd
);
	import slmt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd.op        = OP_NOP;
		cmd.load_item = 1'b0;
		item_ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load_item = 1'b1;
					if (opcode == IN_COMPUTE) begin
						cmd.op  = OP_START;
						state_d = status.empty ? ST_NONE : ST_ROW;
					end
				end
			end
			ST_ROW: begin
				cmd.op  = OP_ROW;
				state_d = ST_FILL_RD;
			end
			ST_FILL_RD: begin
				cmd.op  = OP_FILL_RD;
				state_d = ST_FILL_WR;
			end
			ST_FILL_WR: begin
				cmd.op = OP_FILL_WR;
				if (!status.col_last) begin
					state_d = ST_FILL_RD;
				end else if (status.row_last) begin
					state_d = ST_TB_INIT;
				end else begin
					state_d = ST_ROW;
				end
			end
			ST_TB_INIT: begin
				cmd.op  = OP_TB_INIT;
				state_d = ST_TB_CHECK;
			end
			ST_TB_CHECK: begin
				if (status.tb_live) begin
					state_d = ST_TB_HERE;
				end else begin
					state_d = status.has_hits ? ST_PEN1 : ST_NONE;
				end
			end
			ST_TB_HERE: begin
				cmd.op  = OP_TB_HERE;
				state_d = ST_TB_UP;
			end
			ST_TB_UP: begin
				cmd.op  = OP_TB_UP;
				state_d = ST_TB_UPCMP;
			end
			ST_TB_UPCMP: begin
				if (status.up_eq) begin
					cmd.op  = OP_STEP_UP;
					state_d = ST_TB_CHECK;
				end else begin
					cmd.op  = OP_TB_LEFT;
					state_d = ST_TB_LEFT;
				end
			end
			ST_TB_LEFT: begin
				if (status.left_eq) begin
					cmd.op  = OP_STEP_LEFT;
					state_d = ST_TB_CHECK;
				end else begin
					// a gap square is due once an earlier match exists
					cmd.op  = OP_RECORD;
					state_d = status.has_hits ? ST_ACC : ST_TB_CHECK;
				end
			end
			ST_ACC: begin
				cmd.op  = OP_ACC;
				state_d = ST_TB_CHECK;
			end
			ST_PEN1: begin
				cmd.op  = OP_PEN1;
				state_d = ST_PEN2;
			end
			ST_PEN2: begin
				cmd.op  = OP_PEN2;
				state_d = ST_EM_RD;
			end
			ST_EM_RD: begin
				cmd.op  = OP_EM_RD;
				state_d = ST_EM_LD;
			end
			ST_EM_LD: begin
				if (status.out_free) begin
					cmd.op  = OP_EM_LD;
					state_d = status.emit_last ? ST_FINISH : ST_EM_RD;
				end
			end
			ST_NONE: begin
				if (status.out_free) begin
					cmd.op  = OP_NONE_LD;
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.op  = OP_FINISH;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/slmt_dp.sv @@
// datapath: query, candidate, table and hit memories, counters,
// penalty accumulator and the result register; depends on slmt_pkg
module slmt_dp #(
	parameter int MAX_CAND_LEN  = slmt_pkg::DEF_MAX_CAND_LEN,
	parameter int MAX_QUERY_LEN = slmt_pkg::DEF_MAX_QUERY_LEN,
	parameter int SET_SIZE      = slmt_pkg::DEF_SET_SIZE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  slmt_pkg::dp_cmd_t                 cmd,
	output slmt_pkg::dp_status_t              status,
	input  logic [slmt_pkg::OPC_W-1:0]        opcode,
	input  logic signed [slmt_pkg::ID_W-1:0]  id_value,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [slmt_pkg::POS_W-1:0]        match_position,
	output logic                              matched,
	output logic [slmt_pkg::CNT_W-1:0]        match_count,
	output logic [slmt_pkg::PEN_W-1:0]        penalty,
	output logic                              overflow,
	output logic                              last
);
	import slmt_pkg::*;

	localparam int CLW  = $clog2(MAX_CAND_LEN + 1);
	localparam int QLW  = $clog2(MAX_QUERY_LEN + 1);
	localparam int RW   = (MAX_CAND_LEN > 1) ? $clog2(MAX_CAND_LEN) : 1;
	localparam int CW   = (MAX_QUERY_LEN > 1) ? $clog2(MAX_QUERY_LEN) : 1;
	localparam int SZW  = $clog2(SET_SIZE + 1);
	localparam int LW   = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
	localparam int VW   = QLW;
	localparam int DW   = QLW + 1;
	localparam int MW   = (DW > RW) ? DW : RW;
	localparam int SQW  = 2 * MW;
	localparam int ACCW = ((SQW > PEN_W) ? SQW : PEN_W) + 2;
	localparam int TD   = 1 << (RW + CW);
	localparam int PW   = (RW > POS_W) ? RW : POS_W;
	localparam int KW   = POS_W + 1;

	typedef logic [SET_SIZE-1:0][ID_W-1:0] lanes_t;

	// memories
	logic [ID_W-1:0] qmem [MAX_QUERY_LEN];
	lanes_t          cmem_ids [MAX_CAND_LEN];
	logic [SZW-1:0]  cmem_sz [MAX_CAND_LEN];
	logic [VW-1:0]   tmem [TD];
	logic [RW-1:0]   hmem [MAX_CAND_LEN];

	logic [ID_W-1:0] q_rd_q;
	lanes_t          c_ids_rd_q;
	logic [SZW-1:0]  c_sz_rd_q;
	logic [VW-1:0]   t_rd_q;
	logic [RW-1:0]   h_rd_q;
	lanes_t          open_q;

	// control and working registers
	logic [QLW-1:0]   ql_q;
	logic [CLW-1:0]   cl_q;
	logic [SZW-1:0]   open_n_q;
	logic             ovf_q;
	logic [CLW-1:0]   i_q;
	logic [QLW-1:0]   j_q;
	logic [CLW-1:0]   n_q;
	logic [KW-1:0]    k_q;
	logic [VW-1:0]    left_q, diag_q, here_q;
	logic [RW-1:0]    gap_q, last_q, largest_q;
	logic [PEN_W-1:0] sum_q;

	logic [CLW-1:0]      im1, im2;
	logic [QLW-1:0]      jm1, jm2;
	logic [RW+CW-1:0]    t_raddr, t_waddr;
	logic                t_we;
	logic                q_we, c_we, o_we;
	logic                set_hit;
	logic [VW-1:0]       up1, fill_val, up_v, left_v;
	logic [RW-1:0]       pos_m1;
	logic [7:0]          n8, h_addr8;
	logic [KW-1:0]       k1;
	logic [CNT_W-1:0]    cnt;
	logic [DW-1:0]       d_v;
	logic [MW-1:0]       mul_in;
	logic [SQW-1:0]      sq;
	logic [ACCW-1:0]     addend, acc;
	logic [PEN_W-1:0]    sum_next;
	logic [PW-1:0]       h_ext;
	logic                emit_last;

	assign im1     = i_q - CLW'(1);
	assign im2     = i_q - CLW'(2);
	assign jm1     = j_q - QLW'(1);
	assign jm2     = j_q - QLW'(2);
	assign pos_m1  = im1[RW-1:0];
	assign t_waddr = {i_q[RW-1:0], j_q[CW-1:0]};
	assign t_we    = (cmd.op == OP_FILL_WR);

	always_comb begin
		case (cmd.op)
			OP_FILL_RD: t_raddr = {im1[RW-1:0], j_q[CW-1:0]};
			OP_TB_HERE: t_raddr = {im1[RW-1:0], jm1[CW-1:0]};
			OP_TB_UP:   t_raddr = {im2[RW-1:0], jm1[CW-1:0]};
			OP_TB_LEFT: t_raddr = {im1[RW-1:0], jm2[CW-1:0]};
			default:    t_raddr = '0;
		endcase
	end

	assign q_we = cmd.load_item && (opcode == IN_APPEND_Q) &&
		(ql_q < QLW'(MAX_QUERY_LEN));
	assign o_we = cmd.load_item && (opcode == IN_ADD_ID) &&
		(cl_q < CLW'(MAX_CAND_LEN)) && (open_n_q < SZW'(SET_SIZE));
	assign c_we = cmd.load_item && (opcode == IN_CLOSE) &&
		(cl_q < CLW'(MAX_CAND_LEN));

	// membership of the query id in the current position's set
	always_comb begin
		set_hit = 1'b0;
		for (int k = 0; k < SET_SIZE; k++) begin
			if ((SZW'(k) < c_sz_rd_q) && (c_ids_rd_q[k] == q_rd_q)) begin
				set_hit = 1'b1;
			end
		end
	end

	assign up1      = (i_q == '0) ? '0 : t_rd_q;
	assign fill_val = set_hit ? diag_q + VW'(1) : ((up1 > left_q) ? up1 : left_q);
	assign up_v     = (i_q == CLW'(1)) ? '0 : t_rd_q;
	assign left_v   = (j_q == QLW'(1)) ? '0 : t_rd_q;

	// emission walks the hits from the smallest position upward
	assign n8        = 8'(n_q);
	assign k1        = k_q + KW'(1);
	assign h_addr8   = n8 - 8'd1 - 8'(k_q);
	assign emit_last = (8'(k1) == n8) || (k1 == KW'(MAX_OUT));
	assign cnt       = (n8 > 8'(CNT_MAX)) ? CNT_W'(CNT_MAX) : n8[CNT_W-1:0];
	assign h_ext     = PW'(h_rd_q);

	// shared squarer and saturating accumulator
	assign d_v    = DW'(ql_q) - DW'(n_q) + DW'(1);
	assign mul_in = (cmd.op == OP_PEN1) ? MW'(d_v) : MW'(gap_q);
	assign sq     = SQW'(mul_in) * SQW'(mul_in);

	always_comb begin
		if (cmd.op == OP_PEN2) begin
			addend = ACCW'(last_q) + ACCW'(cl_q) - ACCW'(largest_q);
		end else begin
			addend = ACCW'(sq);
		end
		acc      = ACCW'(sum_q) + addend;
		sum_next = (acc > ACCW'(PEN_MAX)) ? PEN_W'(PEN_MAX) : acc[PEN_W-1:0];
	end

	always_comb begin
		status.empty     = (cl_q == '0) || (ql_q == '0);
		status.col_last  = ((j_q + QLW'(1)) == ql_q);
		status.row_last  = ((i_q + CLW'(1)) == cl_q);
		status.tb_live   = (i_q != '0) && (j_q != '0);
		status.up_eq     = (here_q == up_v);
		status.left_eq   = (here_q == left_v);
		status.has_hits  = (n_q != '0);
		status.emit_last = emit_last;
		status.out_free  = !result_valid || result_ready;
	end

	// memory ports and open set lanes
	always_ff @(posedge clk) begin
		if (q_we) begin
			qmem[ql_q[CW-1:0]] <= id_value;
		end
		if (o_we) begin
			open_q[open_n_q[LW-1:0]] <= id_value;
		end
		if (c_we) begin
			cmem_ids[cl_q[RW-1:0]] <= open_q;
			cmem_sz[cl_q[RW-1:0]]  <= open_n_q;
		end
		if (cmd.op == OP_ROW) begin
			c_ids_rd_q <= cmem_ids[i_q[RW-1:0]];
			c_sz_rd_q  <= cmem_sz[i_q[RW-1:0]];
		end
		if (cmd.op == OP_FILL_RD) begin
			q_rd_q <= qmem[j_q[CW-1:0]];
		end
		if (t_we) begin
			tmem[t_waddr] <= fill_val;
		end
		t_rd_q <= tmem[t_raddr];
		if (cmd.op == OP_RECORD) begin
			hmem[n_q[RW-1:0]] <= pos_m1;
		end
		if (cmd.op == OP_EM_RD) begin
			h_rd_q <= hmem[h_addr8[RW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ql_q           <= '0;
			cl_q           <= '0;
			open_n_q       <= '0;
			ovf_q          <= 1'b0;
			i_q            <= '0;
			j_q            <= '0;
			n_q            <= '0;
			k_q            <= '0;
			left_q         <= '0;
			diag_q         <= '0;
			here_q         <= '0;
			gap_q          <= '0;
			last_q         <= '0;
			largest_q      <= '0;
			sum_q          <= '0;
			result_valid   <= 1'b0;
			match_position <= '0;
			matched        <= 1'b0;
			match_count    <= '0;
			penalty        <= '0;
			overflow       <= 1'b0;
			last           <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				case (opcode)
					IN_APPEND_Q: begin
						if (q_we) begin
							ql_q <= ql_q + QLW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					IN_ADD_ID: begin
						if (o_we) begin
							open_n_q <= open_n_q + SZW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					IN_CLOSE: begin
						if (c_we) begin
							cl_q <= cl_q + CLW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						open_n_q <= '0;
					end
					IN_CLEAR_Q: begin
						ql_q <= '0;
					end
					default: begin
					end
				endcase
			end

			if ((cmd.op == OP_EM_LD) || (cmd.op == OP_NONE_LD)) begin
				result_valid <= 1'b1;
			end else if (result_valid && result_ready) begin
				result_valid <= 1'b0;
			end

			case (cmd.op)
				OP_START: begin
					i_q   <= '0;
					j_q   <= '0;
					n_q   <= '0;
					k_q   <= '0;
					sum_q <= '0;
				end
				OP_ROW: begin
					j_q    <= '0;
					left_q <= '0;
					diag_q <= '0;
				end
				OP_FILL_WR: begin
					left_q <= fill_val;
					diag_q <= up1;
					if (status.col_last) begin
						j_q <= '0;
						i_q <= i_q + CLW'(1);
					end else begin
						j_q <= j_q + QLW'(1);
					end
				end
				OP_TB_INIT: begin
					i_q <= cl_q;
					j_q <= ql_q;
				end
				OP_TB_UP: begin
					here_q <= t_rd_q;
				end
				OP_STEP_UP: begin
					i_q <= im1;
				end
				OP_STEP_LEFT: begin
					j_q <= jm1;
				end
				OP_RECORD: begin
					gap_q  <= last_q - pos_m1;
					last_q <= pos_m1;
					if (n_q == '0) begin
						largest_q <= pos_m1;
					end
					n_q <= n_q + CLW'(1);
					i_q <= im1;
					j_q <= jm1;
				end
				OP_ACC, OP_PEN1, OP_PEN2: begin
					sum_q <= sum_next;
				end
				OP_EM_LD: begin
					match_position <= h_ext[POS_W-1:0];
					matched        <= 1'b1;
					match_count    <= emit_last ? cnt : '0;
					penalty        <= emit_last ? sum_q : '0;
					overflow       <= ovf_q;
					last           <= emit_last;
					k_q            <= k1;
				end
				OP_NONE_LD: begin
					match_position <= '0;
					matched        <= 1'b0;
					match_count    <= '0;
					penalty        <= '0;
					overflow       <= ovf_q;
					last           <= 1'b1;
				end
				OP_FINISH: begin
					cl_q     <= '0;
					open_n_q <= '0;
					ovf_q    <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ rtl/set_lcs_match_traceback_unit.sv @@
// Set LCS match with traceback. One input channel (item_valid/item_ready)
// carries opcode and id_value; one output channel (result_valid/result_ready)
// carries the matched candidate positions, ascending.
// Opcodes 0, 1, 2 and 4 load or clear state and give no result. Opcode 3
// runs a compute: for each candidate row the table fill reads the row, then
// reads and writes each cell on the table memory; the traceback runs for at
// most Lc+Lq steps; then the penalty is summed, and each result is a hit
// memory read and a load of the output register. After the last result is
// loaded, the controller passes through its finish state back to idle,
// where the next item is taken. With no match a single result with matched
// 0 and last 1 is given. The last result carries the count and penalty.
// The table memory sets the fill and traceback rate.
// Reset empties query and candidate and clears the overflow flag; memory
// contents are not cleared. When the receiver stalls, the output register
// holds its result and the compute waits for it.
module set_lcs_match_traceback_unit #(
	parameter int MAX_CAND_LEN  = slmt_pkg::DEF_MAX_CAND_LEN,
	parameter int MAX_QUERY_LEN = slmt_pkg::DEF_MAX_QUERY_LEN,
	parameter int SET_SIZE      = slmt_pkg::DEF_SET_SIZE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic [slmt_pkg::OPC_W-1:0]        opcode,
	input  logic signed [slmt_pkg::ID_W-1:0]  id_value,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [slmt_pkg::POS_W-1:0]        match_position,
	output logic                              matched,
	output logic [slmt_pkg::CNT_W-1:0]        match_count,
	output logic [slmt_pkg::PEN_W-1:0]        penalty,
	output logic                              overflow,
	output logic                              last
);
	import slmt_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	slmt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.opcode     (opcode),
		.status     (status),
		.cmd        (cmd)
	);

	slmt_dp #(
		.MAX_CAND_LEN  (MAX_CAND_LEN),
		.MAX_QUERY_LEN (MAX_QUERY_LEN),
		.SET_SIZE      (SET_SIZE)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.opcode         (opcode),
		.id_value       (id_value),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.match_position (match_position),
		.matched        (matched),
		.match_count    (match_count),
		.penalty        (penalty),
		.overflow       (overflow),
		.last           (last)
	);

endmodule

@@ verif/slmt_checker.sv @@
// checker for the set lcs match traceback unit: watches both channels, predicts results
// from the loaded query and candidate sets, and compares them; depends on slmt_pkg
`timescale 1ns / 1ps

module slmt_checker
	import slmt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	input  logic                    item_ready,
	input  logic [OPC_W-1:0]        opcode,
	input  logic signed [ID_W-1:0]  id_value,
	input  logic                    result_valid,
	input  logic                    result_ready,
	input  logic [POS_W-1:0]        match_position,
	input  logic                    matched,
	input  logic [CNT_W-1:0]        match_count,
	input  logic [PEN_W-1:0]        penalty,
	input  logic                    overflow,
	input  logic                    last,
	output int                      pending,
	output int                      fail_count
);

	localparam int CAND_N  = DEF_MAX_CAND_LEN;
	localparam int QUERY_N = DEF_MAX_QUERY_LEN;
	localparam int SET_N   = DEF_SET_SIZE;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             hit;
		logic [CNT_W-1:0] cnt;
		logic [PEN_W-1:0] pen;
		logic             ovf;
		logic             fin;
	} match_rec_t;

	match_rec_t match_q[$];

	logic [ID_W-1:0] query_ids [QUERY_N];
	logic [ID_W-1:0] cand_ids [CAND_N][SET_N];
	int              cand_sizes [CAND_N];
	int              query_len;
	int              cand_len;
	int              open_len;
	logic            ovf_flag;

	// fill the lcs table, trace it back and queue the matched positions
	task automatic run_match();
		int         tbl [CAND_N+1][QUERY_N+1];
		int         hits [CAND_N];
		int         n, i, j, k, sum, d;
		bit         found;
		match_rec_t rec;
		n = 0;
		for (i = 0; i <= CAND_N; i++)
			for (j = 0; j <= QUERY_N; j++)
				tbl[i][j] = 0;
		for (i = 0; i < cand_len; i++) begin
			for (j = 0; j < query_len; j++) begin
				found = 0;
				for (k = 0; k < cand_sizes[i]; k++)
					if (cand_ids[i][k] == query_ids[j])
						found = 1;
				if (found)
					tbl[i+1][j+1] = tbl[i][j] + 1;
				else
					tbl[i+1][j+1] = (tbl[i][j+1] > tbl[i+1][j]) ?
						tbl[i][j+1] : tbl[i+1][j];
			end
		end
		i = cand_len;
		j = query_len;
		while (i > 0 && j > 0) begin
			if (tbl[i][j] == tbl[i-1][j]) begin
				i--;
			end else if (tbl[i][j] == tbl[i][j-1]) begin
				j--;
			end else begin
				hits[n] = i - 1;
				n++;
				i--;
				j--;
			end
		end
		if (n == 0) begin
			rec = '0;
			rec.ovf = ovf_flag;
			rec.fin = 1'b1;
			match_q.insert(match_q.size(), rec);
		end else begin
			// hits were gathered from the far end, so walk them backwards
			sum = 0;
			for (k = n - 1; k > 0; k--) begin
				d = hits[k-1] - hits[k];
				sum += d * d;
			end
			d = query_len - n + 1;
			sum += d * d + hits[n-1] + (cand_len - hits[0]);
			if (sum > PEN_MAX)
				sum = PEN_MAX;
			for (k = n - 1; k >= 0; k--) begin
				rec.pos = hits[k][POS_W-1:0];
				rec.hit = 1'b1;
				rec.cnt = (k == 0) ? n[CNT_W-1:0] : '0;
				rec.pen = (k == 0) ? sum[PEN_W-1:0] : '0;
				rec.ovf = ovf_flag;
				rec.fin = (k == 0);
				match_q.insert(match_q.size(), rec);
			end
		end
		cand_len = 0;
		open_len = 0;
		ovf_flag = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		match_rec_t want, got;
		if (!arst_n) begin
			match_q.delete();
			query_len  = 0;
			cand_len   = 0;
			open_len   = 0;
			ovf_flag   = 0;
			pending    = 0;
			fail_count <= 0;
		end else begin
			if (result_valid && result_ready) begin
				got = '{match_position, matched, match_count, penalty, overflow, last};
				if (match_q.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result pos %0d matched %0b",
							$realtime, got.pos, got.hit,
							" cnt %0d pen %0d", got.cnt, got.pen);
					fail_count <= fail_count + 1;
				end else begin
					want = match_q.pop_front();
					if (got.pos !== want.pos || got.hit !== want.hit ||
					    got.cnt !== want.cnt || got.pen !== want.pen ||
					    got.ovf !== want.ovf || got.fin !== want.fin) begin
						if (fail_count < 10)
							$display("%0t: result mismatch exp pos %0d m %0b",
								$realtime, want.pos, want.hit,
								" cnt %0d pen %0d ovf %0b last %0b,",
								want.cnt, want.pen, want.ovf, want.fin,
								" got pos %0d m %0b", got.pos, got.hit,
								" cnt %0d pen %0d ovf %0b last %0b",
								got.cnt, got.pen, got.ovf, got.fin);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (item_valid && item_ready) begin
				case (opcode)
					IN_APPEND_Q: begin
						if (query_len < QUERY_N) begin
							query_ids[query_len] = id_value;
							query_len = query_len + 1;
						end else
							ovf_flag = 1;
					end
					IN_ADD_ID: begin
						if (cand_len < CAND_N && open_len < SET_N) begin
							cand_ids[cand_len][open_len] = id_value;
							open_len = open_len + 1;
						end else
							ovf_flag = 1;
					end
					IN_CLOSE: begin
						if (cand_len < CAND_N) begin
							cand_sizes[cand_len] = open_len;
							cand_len = cand_len + 1;
						end else
							ovf_flag = 1;
						open_len = 0;
					end
					IN_COMPUTE: run_match();
					IN_CLEAR_Q: query_len = 0;
					default: ;
				endcase
			end
			pending = match_q.size();
		end
	end

endmodule

@@ verif/testbench.sv @@
// top of the set lcs match traceback unit testbench: clock, reset, item stimulus,
// random stalls and the verdict; depends on slmt_pkg, the unit and slmt_checker
`timescale 1ns / 1ps

module testbench;
	import slmt_pkg::*;

	localparam logic [OPC_W-1:0] OPC_SPARE_FIRST = 3'd5;
	localparam logic [OPC_W-1:0] OPC_SPARE_LAST  = 3'd7;
	localparam int               ITEM_TARGET     = 350;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_ready;
	logic [OPC_W-1:0]       opcode = '0;
	logic signed [ID_W-1:0] id_value = '0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	logic [POS_W-1:0]       match_position;
	logic                   matched;
	logic [CNT_W-1:0]       match_count;
	logic [PEN_W-1:0]       penalty;
	logic                   overflow;
	logic                   last;
	int                     pending;
	int                     fail_count;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int items_sent = 0;
	logic [ID_W-1:0] qpool [8];
	int qpool_len = 0;

	set_lcs_match_traceback_unit u_dut (.*);
	slmt_checker u_chk (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk)
		result_ready <= ($urandom_range(99) >= recv_idle_pct);

	task automatic send(input logic [OPC_W-1:0] op, input logic [ID_W-1:0] id);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		opcode     <= op;
		id_value   <= id;
		do @(posedge clk); while (!item_ready);
		items_sent++;
	endtask

	function automatic logic [ID_W-1:0] rand_id();
		int v;
		if ($urandom_range(1))
			v = $urandom_range(4095);
		else
			v = -int'($urandom_range(2097151, 1));
		return v[ID_W-1:0];
	endfunction

	// mostly ids of the query, so that matches are frequent
	function automatic logic [ID_W-1:0] cand_id();
		if (qpool_len > 0 && $urandom_range(9) < 7)
			return qpool[$urandom_range(qpool_len - 1)];
		return rand_id();
	endfunction

	task automatic new_query(input int len);
		send(IN_CLEAR_Q, rand_id());
		qpool_len = 0;
		for (int k = 0; k < len; k++) begin
			logic [ID_W-1:0] v;
			v = (qpool_len > 0 && $urandom_range(3) == 0) ?
				qpool[$urandom_range(qpool_len - 1)] : rand_id();
			if (qpool_len < 8) begin
				qpool[qpool_len] = v;
				qpool_len++;
			end
			send(IN_APPEND_Q, v);
		end
	endtask

	initial begin
		int clen, ssz, seq;
		seq = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, empty and open positions, set full, empty query
		send(IN_CLEAR_Q, '0);
		send(IN_APPEND_Q, 22'sd4095);
		send(IN_APPEND_Q, -22'sd2097151);
		send(IN_APPEND_Q, '0);
		send(IN_APPEND_Q, 22'sd7);
		send(IN_ADD_ID, 22'sd4095);
		send(IN_ADD_ID, '0);
		send(IN_CLOSE, '0);
		send(IN_CLOSE, '0);
		send(IN_ADD_ID, -22'sd2097151);
		send(IN_CLOSE, '1);
		for (int k = 0; k < 9; k++)
			send(IN_ADD_ID, (k == 8) ? 22'sd7 : ID_W'(100 + k));
		send(IN_CLOSE, '0);
		send(IN_ADD_ID, '0);
		send(OPC_SPARE_FIRST + 3'd1, '1);
		send(IN_COMPUTE, '0);
		send(IN_CLEAR_Q, '0);
		send(IN_ADD_ID, '0);
		send(IN_CLOSE, '0);
		send(IN_COMPUTE, '1);

		while (items_sent < ITEM_TARGET) begin
			case (items_sent * 4 / ITEM_TARGET)
				0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
				1: begin send_idle_pct = 59; recv_idle_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_idle_pct = 59; end
				default: begin send_idle_pct = 8; recv_idle_pct = 8; end
			endcase
			seq++;
			if (seq == 6) begin
				item_valid <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
			end
			if ($urandom_range(9) == 0) begin
				// noise, unused opcodes among it
				send(OPC_W'($urandom_range(OPC_SPARE_LAST)), rand_id());
				continue;
			end
			if (seq % 15 == 7)
				new_query(32 + $urandom_range(2));
			else if (qpool_len == 0 || $urandom_range(3) == 0)
				new_query($urandom_range(6, 1));
			clen = (seq % 13 == 5) ? 33 : $urandom_range(8, 1);
			for (int p = 0; p < clen; p++) begin
				ssz = ($urandom_range(19) == 0) ? 9 : $urandom_range(3);
				for (int k = 0; k < ssz; k++)
					send(IN_ADD_ID, cand_id());
				send(IN_CLOSE, rand_id());
			end
			if ($urandom_range(4) == 0)
				send(IN_ADD_ID, cand_id());
			send(IN_COMPUTE, rand_id());
		end
		item_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
